>>> rtl/core/asou_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asou_pkg
// Shared widths, result codes and small helpers for the segment/box
// overlap unit.
// ----------------------------------------------------------------------------
package asou_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int HALF_WIDTH     = COORD_WIDTH - 1;
  localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
  localparam int MAG_WIDTH      = COORD_WIDTH;
  localparam int LIM_WIDTH      = DIFF_WIDTH + 2;
  localparam int PROD_WIDTH     = 2 * DIFF_WIDTH;
  localparam int SUM_WIDTH      = PROD_WIDTH + 1;
  localparam int BOX_PROD_WIDTH = MAG_WIDTH + HALF_WIDTH;
  localparam int BOX_WIDTH      = BOX_PROD_WIDTH + 1;

  typedef enum logic [1:0] {
    CLS_OUTSIDE = 2'd0,
    CLS_OVERLAP = 2'd1,
    CLS_INSIDE  = 2'd2
  } overlap_class_t;

  typedef logic signed [DIFF_WIDTH-1:0] diff_t;
  typedef logic [HALF_WIDTH-1:0]        half_t;

  function automatic diff_t sext(input logic signed [COORD_WIDTH-1:0] v);
    return DIFF_WIDTH'(v);
  endfunction

  // |diff| <= h
  function automatic logic coord_in(input diff_t diff, input half_t h);
    logic signed [DIFF_WIDTH-1:0] neg;
    logic        [DIFF_WIDTH-1:0] mag;
    neg = -diff;
    mag = diff[DIFF_WIDTH-1] ? neg : diff;
    return mag <= DIFF_WIDTH'(h);
  endfunction

  // box axis test; direction only counts when it points toward the box
  function automatic logic axis_sep(input diff_t d0, input diff_t d, input half_t h);
    logic signed [LIM_WIDTH-1:0] p0;
    logic signed [LIM_WIDTH-1:0] dp;
    logic signed [LIM_WIDTH-1:0] hh;
    logic signed [LIM_WIDTH-1:0] lim;
    logic                        sep;
    p0 = LIM_WIDTH'(d0);
    dp = LIM_WIDTH'(d);
    hh = signed'({{(LIM_WIDTH-HALF_WIDTH){1'b0}}, h});
    if (p0 > 0) begin
      lim = hh - ((dp < 0) ? dp : '0);
      sep = p0 > lim;
    end else begin
      lim = hh + ((dp > 0) ? dp : '0);
      sep = -p0 > lim;
    end
    return sep;
  endfunction

endpackage : asou_pkg
`default_nettype wire

>>> rtl/core/aabb_segment_overlap_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_segment_overlap_unit
// Classifies a segment against an axis-aligned box (separating axis test).
//
// Input: a beat is taken on a rising edge with start high and busy low. busy
// is always low, so one box/segment pair may enter every cycle.
// Payload: box center and half extents, segment start and end point.
// Output: out_valid strobes for one cycle with out_overlap_class
// (0 outside, 1 overlapped, 2 segment wholly inside the closed box).
// Pipeline: four register stages (differences, multipliers and endpoint/box-axis
// tests, cross sums, result register). Throughput: one pair per cycle.
// Results leave in the order pairs entered. The receiver cannot stall, so
// every result is presented exactly once.
// Reset: rst_n low drops all beats in flight; no results follow until new
// beats enter.
// ----------------------------------------------------------------------------
module aabb_segment_overlap_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_center_x,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_center_y,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_center_z,
  input  wire logic        [asou_pkg::HALF_WIDTH-1:0]  in_half_x,
  input  wire logic        [asou_pkg::HALF_WIDTH-1:0]  in_half_y,
  input  wire logic        [asou_pkg::HALF_WIDTH-1:0]  in_half_z,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_start_z,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_end_y,
  input  wire logic signed [asou_pkg::COORD_WIDTH-1:0] in_end_z,
  output logic                                      out_valid,
  output logic [1:0]                                out_overlap_class
);

  logic               accept;

  asou_pkg::diff_t    d0_nxt [3];
  asou_pkg::diff_t    d_nxt  [3];
  asou_pkg::diff_t    de_nxt [3];
  asou_pkg::half_t    h_nxt  [3];

  logic               a_vld_r, a_vld_nxt;
  asou_pkg::diff_t    a_d0_r [3];
  asou_pkg::diff_t    a_d_r  [3];
  asou_pkg::diff_t    a_de_r [3];
  asou_pkg::half_t    a_h_r  [3];

  logic               b_vld_r, b_vld_nxt;
  logic               b_s_in_r, b_s_in_nxt;
  logic               b_e_in_r, b_e_in_nxt;
  logic               b_axis_r, b_axis_nxt;

  logic               c_vld_r, c_vld_nxt;
  logic               c_s_in_r;
  logic               c_e_in_r;
  logic               c_axis_r;

  logic               sep0, sep1, sep2;
  logic               out_valid_r, out_valid_nxt;
  asou_pkg::overlap_class_t cls_r, cls_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage A: differences
  always_comb begin
    h_nxt[0]  = in_half_x;
    h_nxt[1]  = in_half_y;
    h_nxt[2]  = in_half_z;
    d0_nxt[0] = asou_pkg::sext(in_start_x) - asou_pkg::sext(in_center_x);
    d0_nxt[1] = asou_pkg::sext(in_start_y) - asou_pkg::sext(in_center_y);
    d0_nxt[2] = asou_pkg::sext(in_start_z) - asou_pkg::sext(in_center_z);
    d_nxt[0]  = asou_pkg::sext(in_end_x) - asou_pkg::sext(in_start_x);
    d_nxt[1]  = asou_pkg::sext(in_end_y) - asou_pkg::sext(in_start_y);
    d_nxt[2]  = asou_pkg::sext(in_end_z) - asou_pkg::sext(in_start_z);
    de_nxt[0] = asou_pkg::sext(in_end_x) - asou_pkg::sext(in_center_x);
    de_nxt[1] = asou_pkg::sext(in_end_y) - asou_pkg::sext(in_center_y);
    de_nxt[2] = asou_pkg::sext(in_end_z) - asou_pkg::sext(in_center_z);
    a_vld_nxt = accept;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_d0_r[i] <= d0_nxt[i];
      a_d_r[i]  <= d_nxt[i];
      a_de_r[i] <= de_nxt[i];
      a_h_r[i]  <= h_nxt[i];
    end
  end

  // stage B: endpoint containment and box axes
  always_comb begin
    b_s_in_nxt = 1'b1;
    b_e_in_nxt = 1'b1;
    b_axis_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      b_s_in_nxt = b_s_in_nxt & asou_pkg::coord_in(a_d0_r[i], a_h_r[i]);
      b_e_in_nxt = b_e_in_nxt & asou_pkg::coord_in(a_de_r[i], a_h_r[i]);
      b_axis_nxt = b_axis_nxt | asou_pkg::axis_sep(a_d0_r[i], a_d_r[i], a_h_r[i]);
    end
    b_vld_nxt = a_vld_r;
  end

  always_ff @(posedge clk) begin
    b_s_in_r <= b_s_in_nxt;
    b_e_in_r <= b_e_in_nxt;
    b_axis_r <= b_axis_nxt;
    c_s_in_r <= b_s_in_r;
    c_e_in_r <= b_e_in_r;
    c_axis_r <= b_axis_r;
  end

  assign c_vld_nxt = b_vld_r;

  // cross axes: x cross d, y cross d, z cross d
  asou_cross_axis u_cross0 (
    .clk (clk),
    .x   (a_d_r[1]), .y (a_d0_r[2]), .hy (a_h_r[2]),
    .z   (a_d_r[2]), .w (a_d0_r[1]), .hw (a_h_r[1]),
    .sep (sep0)
  );

  asou_cross_axis u_cross1 (
    .clk (clk),
    .x   (a_d_r[2]), .y (a_d0_r[0]), .hy (a_h_r[0]),
    .z   (a_d_r[0]), .w (a_d0_r[2]), .hw (a_h_r[2]),
    .sep (sep1)
  );

  asou_cross_axis u_cross2 (
    .clk (clk),
    .x   (a_d_r[0]), .y (a_d0_r[1]), .hy (a_h_r[1]),
    .z   (a_d_r[1]), .w (a_d0_r[0]), .hw (a_h_r[0]),
    .sep (sep2)
  );

  // final stage: classify
  always_comb begin
    if (c_s_in_r && c_e_in_r) begin
      cls_nxt = asou_pkg::CLS_INSIDE;
    end else if (c_s_in_r || c_e_in_r) begin
      cls_nxt = asou_pkg::CLS_OVERLAP;
    end else if (c_axis_r || sep0 || sep1 || sep2) begin
      cls_nxt = asou_pkg::CLS_OUTSIDE;
    end else begin
      cls_nxt = asou_pkg::CLS_OVERLAP;
    end
    out_valid_nxt = c_vld_r;
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= a_vld_nxt;
      b_vld_r     <= b_vld_nxt;
      c_vld_r     <= c_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_overlap_class = cls_r;

endmodule : aabb_segment_overlap_unit
`default_nettype wire

>>> rtl/core/asou_cross_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asou_cross_axis
// One cross-product axis: |x*y - z*w| > |x|*hy + |z|*hw, two register stages.
// ----------------------------------------------------------------------------
module asou_cross_axis (
  input  wire logic                clk,
  input  wire asou_pkg::diff_t     x,
  input  wire asou_pkg::diff_t     y,
  input  wire asou_pkg::half_t     hy,
  input  wire asou_pkg::diff_t     z,
  input  wire asou_pkg::diff_t     w,
  input  wire asou_pkg::half_t     hw,
  output logic                     sep
);

  logic signed [asou_pkg::DIFF_WIDTH-1:0]     x_abs;
  logic signed [asou_pkg::DIFF_WIDTH-1:0]     z_abs;
  logic        [asou_pkg::MAG_WIDTH-1:0]      x_mag;
  logic        [asou_pkg::MAG_WIDTH-1:0]      z_mag;

  logic signed [asou_pkg::PROD_WIDTH-1:0]     pxy_r, pxy_nxt;
  logic signed [asou_pkg::PROD_WIDTH-1:0]     pzw_r, pzw_nxt;
  logic        [asou_pkg::BOX_PROD_WIDTH-1:0] bx_r, bx_nxt;
  logic        [asou_pkg::BOX_PROD_WIDTH-1:0] bz_r, bz_nxt;

  logic signed [asou_pkg::SUM_WIDTH-1:0]      p_sum;
  logic signed [asou_pkg::SUM_WIDTH-1:0]      p_neg;
  logic        [asou_pkg::SUM_WIDTH-1:0]      pm_r, pm_nxt;
  logic        [asou_pkg::BOX_WIDTH-1:0]      bs_r, bs_nxt;

  always_comb begin
    x_abs   = x[asou_pkg::DIFF_WIDTH-1] ? -x : x;
    z_abs   = z[asou_pkg::DIFF_WIDTH-1] ? -z : z;
    x_mag   = x_abs[asou_pkg::MAG_WIDTH-1:0];
    z_mag   = z_abs[asou_pkg::MAG_WIDTH-1:0];
    pxy_nxt = x * y;
    pzw_nxt = z * w;
    bx_nxt  = x_mag * hy;
    bz_nxt  = z_mag * hw;
  end

  always_comb begin
    p_sum  = asou_pkg::SUM_WIDTH'(pxy_r) - asou_pkg::SUM_WIDTH'(pzw_r);
    p_neg  = -p_sum;
    pm_nxt = p_sum[asou_pkg::SUM_WIDTH-1] ? p_neg : p_sum;
    bs_nxt = asou_pkg::BOX_WIDTH'(bx_r) + asou_pkg::BOX_WIDTH'(bz_r);
  end

  always_ff @(posedge clk) begin
    pxy_r <= pxy_nxt;
    pzw_r <= pzw_nxt;
    bx_r  <= bx_nxt;
    bz_r  <= bz_nxt;
    pm_r  <= pm_nxt;
    bs_r  <= bs_nxt;
  end

  assign sep = pm_r > asou_pkg::SUM_WIDTH'(bs_r);

endmodule : asou_cross_axis
`default_nettype wire

>>> rtl/core/asou_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asou_checker
// Port-level checks for the segment/box overlap unit, bound to the top level.
// ----------------------------------------------------------------------------
module asou_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_overlap_class
);

  // every accepted beat yields a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted beat produced no result");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start, 4) && !$past(busy, 4)))
    else $error("result without accepted beat");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overlap_class != 2'd3))
    else $error("illegal overlap class");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("unit reported busy");

endmodule : asou_checker

bind aabb_segment_overlap_unit asou_checker u_asou_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_overlap_class (out_overlap_class)
);
`default_nettype wire

>>> verif/aabb_segment_overlap_checker.sv
// ----------------------------------------------------------------------------
// aabb_segment_overlap_checker
// Watches the command and result ports of the segment/box overlap unit,
// predicts the class of every accepted pair with an independent separating
// axis calculation in 64-bit integers, and compares results in order.
// ----------------------------------------------------------------------------
module aabb_segment_overlap_checker
  import asou_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_center_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_center_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_center_z,
  input  wire logic        [HALF_WIDTH-1:0]  in_half_x,
  input  wire logic        [HALF_WIDTH-1:0]  in_half_y,
  input  wire logic        [HALF_WIDTH-1:0]  in_half_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_z,
  input  wire logic                          out_valid,
  input  wire logic [1:0]                    out_overlap_class,
  output int                                 mismatch_count,
  output int                                 outstanding
);

  overlap_class_t pending_classes[$];
  int             error_total = 0;

  function automatic bit within_half(input longint p, input longint c, input longint h);
    longint d;
    d = p - c;
    if (d < 0) d = -d;
    return d <= h;
  endfunction

  // segment direction only widens the slab on the side facing the box
  function automatic bit box_axis_gap(input longint p0, input longint dp, input longint h);
    if (p0 > 0) return p0 > h - ((dp < 0) ? dp : 0);
    return -p0 > h + ((dp > 0) ? dp : 0);
  endfunction

  function automatic bit cross_axis_gap(input longint a1, input longint b1, input longint h1,
                                        input longint a2, input longint b2, input longint h2);
    longint proj;
    longint reach;
    proj  = a1 * b1 + a2 * b2;
    reach = ((a1 < 0) ? -a1 : a1) * h1 + ((a2 < 0) ? -a2 : a2) * h2;
    if (proj < 0) proj = -proj;
    return proj > reach;
  endfunction

  function automatic overlap_class_t classify_pair(
    input longint cx, input longint cy, input longint cz,
    input longint hx, input longint hy, input longint hz,
    input longint sx, input longint sy, input longint sz,
    input longint ex, input longint ey, input longint ez);
    bit     s_in;
    bit     e_in;
    longint ox, oy, oz;
    longint dx, dy, dz;
    s_in = within_half(sx, cx, hx) && within_half(sy, cy, hy) && within_half(sz, cz, hz);
    e_in = within_half(ex, cx, hx) && within_half(ey, cy, hy) && within_half(ez, cz, hz);
    if (s_in && e_in) return CLS_INSIDE;
    if (s_in || e_in) return CLS_OVERLAP;
    ox = sx - cx; oy = sy - cy; oz = sz - cz;
    dx = ex - sx; dy = ey - sy; dz = ez - sz;
    if (box_axis_gap(ox, dx, hx) || box_axis_gap(oy, dy, hy) || box_axis_gap(oz, dz, hz))
      return CLS_OUTSIDE;
    if (cross_axis_gap(-dz, oy, hy, dy, oz, hz)) return CLS_OUTSIDE;
    if (cross_axis_gap(dz, ox, hx, -dx, oz, hz)) return CLS_OUTSIDE;
    if (cross_axis_gap(-dy, ox, hx, dx, oy, hy)) return CLS_OUTSIDE;
    return CLS_OVERLAP;
  endfunction

  always @(posedge clk) begin
    overlap_class_t want;
    if (rst_n) begin
      // check before queueing so a stray result never pairs with a fresh beat
      if (out_valid) begin
        if (pending_classes.size() == 0) begin
          error_total = error_total + 1;
          if (error_total <= 10)
            $display("unexpected result class %0d with nothing pending", out_overlap_class);
        end else begin
          want = pending_classes.pop_front();
          if (out_overlap_class !== want) begin
            error_total = error_total + 1;
            if (error_total <= 10)
              $display("class mismatch: expected %0d, got %0d", want, out_overlap_class);
          end
        end
      end
      if (start && !busy)
        pending_classes.push_back(classify_pair(
          longint'(in_center_x), longint'(in_center_y), longint'(in_center_z),
          longint'(in_half_x), longint'(in_half_y), longint'(in_half_z),
          longint'(in_start_x), longint'(in_start_y), longint'(in_start_z),
          longint'(in_end_x), longint'(in_end_y), longint'(in_end_z)));
    end
    mismatch_count <= error_total;
    outstanding    <= pending_classes.size();
  end

endmodule

>>> verif/tb_aabb_segment_overlap_unit.sv
// ----------------------------------------------------------------------------
// tb_aabb_segment_overlap_unit
// Drives the segment/box overlap unit with directed corner pairs followed by
// random pairs (noise, near-box segments, face hits, crossings, zero-length
// segments) under random issue gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_aabb_segment_overlap_unit;
  import asou_pkg::*;

  localparam int RANDOM_PAIRS = 1200;
  localparam int CYCLE_LIMIT  = 100000;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] cx, cy, cz;
    logic [HALF_WIDTH-1:0]  hx, hy, hz;
    logic [COORD_WIDTH-1:0] sx, sy, sz;
    logic [COORD_WIDTH-1:0] ex, ey, ez;
  } pair_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [COORD_WIDTH-1:0] in_center_x = '0;
  logic signed [COORD_WIDTH-1:0] in_center_y = '0;
  logic signed [COORD_WIDTH-1:0] in_center_z = '0;
  logic        [HALF_WIDTH-1:0]  in_half_x = '0;
  logic        [HALF_WIDTH-1:0]  in_half_y = '0;
  logic        [HALF_WIDTH-1:0]  in_half_z = '0;
  logic signed [COORD_WIDTH-1:0] in_start_x = '0;
  logic signed [COORD_WIDTH-1:0] in_start_y = '0;
  logic signed [COORD_WIDTH-1:0] in_start_z = '0;
  logic signed [COORD_WIDTH-1:0] in_end_x = '0;
  logic signed [COORD_WIDTH-1:0] in_end_y = '0;
  logic signed [COORD_WIDTH-1:0] in_end_z = '0;
  logic                          out_valid;
  logic [1:0]                    out_overlap_class;
  int                            mismatch_count;
  int                            outstanding;
  int                            cycle_count = 0;

  aabb_segment_overlap_unit dut (.*);
  aabb_segment_overlap_checker checker_i (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic pair_t mk(input int cx, input int cy, input int cz,
                               input int hx, input int hy, input int hz,
                               input int sx, input int sy, input int sz,
                               input int ex, input int ey, input int ez);
    pair_t p;
    p.cx = COORD_WIDTH'(cx); p.cy = COORD_WIDTH'(cy); p.cz = COORD_WIDTH'(cz);
    p.hx = HALF_WIDTH'(hx);  p.hy = HALF_WIDTH'(hy);  p.hz = HALF_WIDTH'(hz);
    p.sx = COORD_WIDTH'(sx); p.sy = COORD_WIDTH'(sy); p.sz = COORD_WIDTH'(sz);
    p.ex = COORD_WIDTH'(ex); p.ey = COORD_WIDTH'(ey); p.ez = COORD_WIDTH'(ez);
    return p;
  endfunction

  function automatic int near_offset(input int scale, input int h);
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return ($urandom_range(0, 1) != 0) ? h : -h;  // exactly on a face
    return int'($urandom_range(0, 4 * scale)) - 2 * scale;
  endfunction

  function automatic pair_t random_pair();
    pair_t           p;
    logic [191:0]    noise;
    int              sel;
    int              scale;
    int              c[3];
    int              h[3];
    int              os[3];
    int              oe[3];
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = noise[$bits(pair_t)-1:0];
      return p;
    end
    case ($urandom_range(0, 3))
      0: scale = 8;
      1: scale = 256;
      2: scale = 8192;
      default: scale = 32767;
    endcase
    for (int i = 0; i < 3; i++) begin
      c[i]  = int'($urandom_range(0, 65535)) - 32768;
      h[i]  = $urandom_range(0, scale);
      os[i] = near_offset(scale, h[i]);
      if (sel == 9) oe[i] = os[i];                                        // zero length
      else if (sel >= 6) oe[i] = -os[i] + int'($urandom_range(0, 4)) - 2;  // crosses box
      else oe[i] = near_offset(scale, h[i]);
    end
    return mk(c[0], c[1], c[2], h[0], h[1], h[2],
              c[0] + os[0], c[1] + os[1], c[2] + os[2],
              c[0] + oe[0], c[1] + oe[1], c[2] + oe[2]);
  endfunction

  task automatic send_pair(input pair_t p);
    in_center_x <= p.cx; in_center_y <= p.cy; in_center_z <= p.cz;
    in_half_x   <= p.hx; in_half_y   <= p.hy; in_half_z   <= p.hz;
    in_start_x  <= p.sx; in_start_y  <= p.sy; in_start_z  <= p.sz;
    in_end_x    <= p.ex; in_end_y    <= p.ey; in_end_z    <= p.ez;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    pair_t beats[$];
    bit    burst;
    int    gap;
    int    settle;

    beats.push_back(mk(0, 0, 0, 100, 100, 100, 10, -20, 30, -40, 50, -60));
    beats.push_back(mk(0, 0, 0, 100, 100, 100, 100, -100, 100, -100, 100, -100));
    beats.push_back(mk(1000, -1000, 500, 10, 10, 10, 1000, -1000, 500, 2000, 0, 0));
    beats.push_back(mk(0, 0, 0, 10, 10, 10, 50, 50, 50, 50, 50, 50));
    beats.push_back(mk(0, 0, 0, 10, 10, 10, 10, 0, 0, 10, 0, 0));
    beats.push_back(mk(0, 0, 0, 10, 10, 10, -50, 0, 0, 50, 0, 0));
    beats.push_back(mk(0, 0, 0, 10, 10, 10, -60, 35, 0, 35, -60, 0));
    beats.push_back(mk(0, 0, 0, 10, 10, 10, 20, 0, 0, 40, 0, 0));
    beats.push_back(mk(0, 0, 0, 10, 10, 10, 20, 0, 0, 5, 0, 0));
    beats.push_back(mk(0, 0, 0, 0, 0, 0, -5, -5, -5, 5, 5, 5));
    beats.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    beats.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                       32767, 32767, 32767, -32768, -32768, -32768));
    beats.push_back(mk(32767, 32767, 32767, 0, 0, 0,
                       -32768, -32768, -32768, -32768, -32768, -32768));
    beats.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                       32767, 32767, 32767, 32767, 32767, 32767));
    beats.push_back(mk(32767, -32768, 0, 32767, 32767, 32767,
                       -32768, 32767, 0, 32767, -32768, 0));
    beats.push_back(mk(0, 0, 0, 32767, 32767, 32767,
                       -32768, -32768, -32768, 32767, 32767, 32767));
    beats.push_back(mk(-1, -1, -1, 1, 1, 1, 0, 0, 0, -2, -2, -2));
    beats.push_back(mk(100, 100, 100, 5, 5, 5, 0, 0, 0, 200, 200, 201));
    beats.push_back(mk(0, 0, 0, 5, 5, 5, -20, 6, 0, 20, 6, 0));
    beats.push_back(mk(0, 0, 0, 5, 5, 5, -20, 5, 0, 20, 5, 0));
    beats.push_back(mk(0, 0, 0, 5, 5, 5, 0, -20, 20, 0, 20, -20));
    beats.push_back(mk(0, 0, 0, 5, 5, 5, 0, -20, 31, 0, 31, -20));
    for (int i = 0; i < RANDOM_PAIRS; i++) beats.push_back(random_pair());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst = 1'b0;
    for (int i = 0; i < beats.size(); i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      send_pair(beats[i]);
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    settle = 0;
    while (settle < 12) begin
      @(posedge clk);
      settle++;
    end

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
